/* hdl/least_loaded_slot_allocator_assert.svh */
// Assertion macros for the least loaded slot allocator.
// Expects clk and rst_n in the scope of use; empty when SYNTHESIS is defined.
`ifndef LEAST_LOADED_SLOT_ALLOCATOR_ASSERT_SVH
`define LEAST_LOADED_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define LLSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define LLSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LLSA_ASSERT_SAME(label, ante, cons, msg)
`define LLSA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* hdl/llsa_pkg.sv */
// Shared types and constants for the least loaded slot allocator.
// No dependencies; used by the interfaces, the top module, the sequencer and the count unit.
package llsa_pkg;

    // Fixed field widths
    localparam int SLOT_W = 4;
    localparam int LOAD_W = 16;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] SLOTS_RESET = 5'd16;

    // Request kinds
    localparam logic FUNC_ASSIGN  = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_SCAN,
        ST_FIN
    } state_t;

    // Operations of the shared count unit
    typedef enum logic [1:0] {
        ALU_CMP,
        ALU_INC,
        ALU_DEC
    } alu_op_t;

    // Status into the sequencer
    typedef struct packed {
        logic req_valid;
        logic req_release;
        logic rel_bad;
        logic item_release;
        logic out_free;
    } seq_sts_t;

    // Control out of the sequencer
    typedef struct packed {
        logic ready;
        logic cmp_en;
        logic first;
        logic fin;
        logic fin_fire;
    } seq_ctrl_t;

endpackage

/* hdl/llsa_if.sv */
// Request and response channel interfaces for the least loaded slot allocator.
// Depends on llsa_pkg for the field widths.
interface llsa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [llsa_pkg::SLOT_W-1:0]   release_slot;

    modport source (output valid, output func, output release_slot, input ready);
    modport sink   (input valid, input func, input release_slot, output ready);
endinterface

interface llsa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [llsa_pkg::SLOT_W-1:0]   slot;
    logic [llsa_pkg::LOAD_W-1:0]   load;
    logic                          error;

    modport source (output valid, output slot, output load, output error, input ready);
    modport sink   (input valid, input slot, input load, input error, output ready);
endinterface

/* hdl/least_loaded_slot_allocator.sv */
// Least loaded slot allocator: one load count per slot, scanned one slot per cycle.
// Assign: the scan compares every active slot, then the least loaded count is stepped.
// Release: one slot is read and stepped; a bad slot goes straight to the result.
// The next request is taken once the result is registered; a held response beat adds its wait.
// Reset: counts read as zero through per-slot valid bits, slots_in_use = 16, no clearing pass.
`include "least_loaded_slot_allocator_assert.svh"
module least_loaded_slot_allocator #(
    parameter int MAX_SLOTS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    llsa_req_if.sink                     req,
    llsa_rsp_if.source                   rsp,
    input  logic                         cfg_we,
    input  logic [llsa_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int CFG_W  = llsa_pkg::CFG_W;
    localparam int NW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SLOT_W = llsa_pkg::SLOT_W;
    localparam int LOAD_W = llsa_pkg::LOAD_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [CFG_W-1:0]       cfg_reg;
    logic [NW-1:0]          cfg_ext;
    logic [NW-1:0]          n_eff;
    logic [IDX_W-1:0]       last_idx;
    logic [IDX_W-1:0]       start_idx;
    logic                   rel_bad;

    llsa_pkg::seq_sts_t     sts;
    llsa_pkg::seq_ctrl_t    ctrl;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       cmp_idx;
    logic [COUNT_BITS-1:0]  rd_data;

    logic                   func_reg;
    logic [SLOT_W-1:0]      rel_reg;
    logic                   bad_reg;
    logic [COUNT_BITS-1:0]  best_val_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [MAX_SLOTS-1:0]   slot_vld_reg;

    logic [COUNT_BITS-1:0]  cur_val;
    llsa_pkg::alu_op_t      alu_op;
    logic [COUNT_BITS-1:0]  alu_a;
    logic                   alu_lt;
    logic                   alu_lim;
    logic [COUNT_BITS-1:0]  alu_res;
    logic                   fin_err;
    logic                   ram_we;

    logic                   out_valid_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [LOAD_W-1:0]      out_load_reg;
    logic                   out_err_reg;
    logic                   accept;

    // Slot count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= llsa_pkg::SLOTS_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    // Effective slot count, clamped to 2..MAX_SLOTS
    always_comb
    begin
        cfg_ext = NW'(cfg_reg);
        if (cfg_ext < NW'(2))
        begin
            n_eff = NW'(2);
        end
        else if (cfg_ext > NW'(MAX_SLOTS))
        begin
            n_eff = NW'(MAX_SLOTS);
        end
        else
        begin
            n_eff = cfg_ext;
        end
    end

    assign last_idx  = IDX_W'(n_eff - NW'(1));
    assign rel_bad   = NW'(req.release_slot) >= n_eff;
    assign start_idx = (req.func == llsa_pkg::FUNC_RELEASE) ? IDX_W'(req.release_slot) : '0;
    assign accept    = req.valid && ctrl.ready;

    // Sequencer
    assign sts.req_valid    = req.valid;
    assign sts.req_release  = (req.func == llsa_pkg::FUNC_RELEASE);
    assign sts.rel_bad      = rel_bad;
    assign sts.item_release = (func_reg == llsa_pkg::FUNC_RELEASE);
    assign sts.out_free     = !out_valid_reg || rsp.ready;

    llsa_seq #(
        .IDX_W (IDX_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .sts       (sts),
        .start_idx (start_idx),
        .last_idx  (last_idx),
        .ctrl      (ctrl),
        .rd_addr   (rd_addr),
        .cmp_idx   (cmp_idx)
    );

    // Count store
    llsa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (best_idx_reg),
        .wdata (alu_res),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Shared unit: compare while scanning, step the chosen count at the end
    assign cur_val = slot_vld_reg[cmp_idx] ? rd_data : '0;
    assign alu_a   = ctrl.fin ? best_val_reg : cur_val;

    always_comb
    begin
        if (ctrl.cmp_en)
        begin
            alu_op = llsa_pkg::ALU_CMP;
        end
        else if (func_reg == llsa_pkg::FUNC_ASSIGN)
        begin
            alu_op = llsa_pkg::ALU_INC;
        end
        else
        begin
            alu_op = llsa_pkg::ALU_DEC;
        end
    end

    llsa_alu #(
        .W (COUNT_BITS)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (best_val_reg),
        .lt  (alu_lt),
        .lim (alu_lim),
        .res (alu_res)
    );

    assign fin_err = bad_reg || alu_lim;
    assign ram_we  = ctrl.fin_fire && !fin_err;

    // Request beat capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            rel_reg  <= req.release_slot;
            bad_reg  <= (req.func == llsa_pkg::FUNC_RELEASE) && rel_bad;
        end
    end

    // Running minimum; strict compare keeps the lowest slot on a tie
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en && (ctrl.first || alu_lt))
        begin
            best_val_reg <= cur_val;
            best_idx_reg <= cmp_idx;
        end
    end

    // Per-slot valid bits: an unwritten slot reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
        end
        else if (ram_we)
        begin
            slot_vld_reg[best_idx_reg] <= 1'b1;
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.fin_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fin_fire)
        begin
            out_slot_reg <= (func_reg == llsa_pkg::FUNC_RELEASE) ? rel_reg
                                                                 : SLOT_W'(best_idx_reg);
            out_load_reg <= bad_reg ? '0 : LOAD_W'(alu_res);
            out_err_reg  <= fin_err;
        end
    end

    assign req.ready = ctrl.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.slot  = out_slot_reg;
    assign rsp.load  = out_load_reg;
    assign rsp.error = out_err_reg;

    // Checks
    `LLSA_ASSERT_SAME(a_no_overwrite, ctrl.fin_fire, !out_valid_reg || rsp.ready, "response overwritten")
    `LLSA_ASSERT_NEXT(a_busy_after_beat, req.valid && req.ready, !req.ready, "ready after request beat")
    `LLSA_ASSERT_SAME(a_scan_in_range, ctrl.cmp_en, cmp_idx <= last_idx, "scan beyond active slots")
    `LLSA_ASSERT_SAME(a_no_wrap, ram_we, (func_reg == llsa_pkg::FUNC_ASSIGN) ? (best_val_reg != CNT_MAX) : (best_val_reg != '0), "count wrapped")

endmodule

/* hdl/llsa_ram.sv */
// Generic single write, single read RAM with registered read data.
// No dependencies.
module llsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hdl/llsa_alu.sv */
// Shared count unit: compare during the scan, saturating step at the end.
// Depends on llsa_pkg for the operation codes.
module llsa_alu #(
    parameter int W = 16
) (
    input  llsa_pkg::alu_op_t op,
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    output logic              lt,
    output logic              lim,
    output logic [W-1:0]      res
);

    localparam logic [W-1:0] ONE = W'(1);

    // One compare and one incrementer/decrementer, selected by op
    always_comb
    begin
        lt  = a < b;
        lim = 1'b0;
        res = a;
        unique case (op)
            llsa_pkg::ALU_CMP:
            begin
                lim = 1'b0;
                res = a;
            end
            llsa_pkg::ALU_INC:
            begin
                lim = (a == '1);
                res = lim ? a : a + ONE;
            end
            llsa_pkg::ALU_DEC:
            begin
                lim = (a == '0);
                res = lim ? a : a - ONE;
            end
            default:
            begin
                lim = 1'b0;
                res = a;
            end
        endcase
    end

endmodule

/* hdl/llsa_seq.sv */
// Sequencer: walks the slot counts one RAM read a cycle and paces each request.
// Depends on llsa_pkg for the state type and control structs.
module llsa_seq #(
    parameter int IDX_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  llsa_pkg::seq_sts_t   sts,
    input  logic [IDX_W-1:0]     start_idx,
    input  logic [IDX_W-1:0]     last_idx,
    output llsa_pkg::seq_ctrl_t  ctrl,
    output logic [IDX_W-1:0]     rd_addr,
    output logic [IDX_W-1:0]     cmp_idx
);

    llsa_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             first_reg, first_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            llsa_pkg::ST_IDLE:
            begin
                if (sts.req_valid)
                begin
                    state_next = (sts.req_release && sts.rel_bad) ? llsa_pkg::ST_FIN
                                                                  : llsa_pkg::ST_ISSUE;
                end
            end
            llsa_pkg::ST_ISSUE:
            begin
                state_next = llsa_pkg::ST_SCAN;
            end
            llsa_pkg::ST_SCAN:
            begin
                if (sts.item_release || cmp_idx_reg == last_idx)
                begin
                    state_next = llsa_pkg::ST_FIN;
                end
            end
            llsa_pkg::ST_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = llsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = llsa_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            llsa_pkg::ST_IDLE:
            begin
                ctrl.ready = 1'b1;
            end
            llsa_pkg::ST_ISSUE:
            begin
                ctrl.ready = 1'b0;
            end
            llsa_pkg::ST_SCAN:
            begin
                ctrl.cmp_en = 1'b1;
                ctrl.first  = first_reg;
            end
            llsa_pkg::ST_FIN:
            begin
                ctrl.fin      = 1'b1;
                ctrl.fin_fire = sts.out_free;
            end
            default:
            begin
                ctrl.ready = 1'b0;
            end
        endcase
    end

    // Read index runs one ahead of the compare index and stops at the last slot
    always_comb
    begin
        idx_next     = idx_reg;
        cmp_idx_next = cmp_idx_reg;
        first_next   = 1'b0;
        if (state_reg == llsa_pkg::ST_IDLE)
        begin
            idx_next = start_idx;
        end
        else if (state_reg == llsa_pkg::ST_ISSUE || state_reg == llsa_pkg::ST_SCAN)
        begin
            cmp_idx_next = idx_reg;
            first_next   = (state_reg == llsa_pkg::ST_ISSUE);
            if (idx_reg != last_idx)
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= llsa_pkg::ST_IDLE;
            idx_reg     <= '0;
            cmp_idx_reg <= '0;
            first_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cmp_idx_reg <= cmp_idx_next;
            first_reg   <= first_next;
        end
    end

    assign rd_addr = idx_reg;
    assign cmp_idx = cmp_idx_reg;

endmodule
